// ===== design/ewfe_pkg.sv =====
package ewfe_pkg;

  localparam int unsigned WORD_W              = 16;
  localparam int unsigned BYTE_W              = 8;
  localparam int unsigned WORDS_PER_FRAME_DEF = 16;
  localparam int unsigned QUEUE_DEPTH         = 2;

  localparam logic [BYTE_W-1:0] ESC_BYTE = 8'hFE;
  localparam logic [BYTE_W-1:0] HDR_BYTE = 8'h88;

  // One classified word handed from the front to the back
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              header;
    logic              esc_lo;
    logic              esc_hi;
    logic              frame_end;
  } desc_t;

endpackage

// ===== design/ewfe_front.sv =====
module ewfe_front #(
  parameter int unsigned WORDS_PER_FRAME = ewfe_pkg::WORDS_PER_FRAME_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ewfe_pkg::WORD_W-1:0] word_value_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output ewfe_pkg::desc_t             q_desc_o
);
  import ewfe_pkg::*;

  localparam int unsigned FRAME_SZ = (WORDS_PER_FRAME < 1) ? 1 : WORDS_PER_FRAME;
  localparam int unsigned POS_W    = (FRAME_SZ > 1) ? $clog2(FRAME_SZ) : 1;

  logic [POS_W-1:0] pos_q, pos_d;
  logic             last_of_frame;

  assign in_stall_o    = q_full_i;
  assign q_push_o      = in_valid_i && !q_full_i;
  assign last_of_frame = (pos_q == POS_W'(FRAME_SZ - 1));

  always_comb begin
    q_desc_o.word      = word_value_i;
    q_desc_o.header    = (pos_q == '0);
    q_desc_o.esc_lo    = (word_value_i[BYTE_W-1:0] == ESC_BYTE);
    q_desc_o.esc_hi    = (word_value_i[WORD_W-1:BYTE_W] == ESC_BYTE);
    q_desc_o.frame_end = last_of_frame;
  end

  always_comb begin
    pos_d = pos_q;
    if (q_push_o) begin
      pos_d = last_of_frame ? '0 : pos_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// ===== design/ewfe_queue.sv =====
module ewfe_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ewfe_pkg::desc_t desc_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output ewfe_pkg::desc_t head_o
);
  import ewfe_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  desc_t            slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== design/ewfe_back.sv =====
module ewfe_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        head_valid_i,
  input  ewfe_pkg::desc_t             head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ewfe_pkg::BYTE_W-1:0] out_byte_o,
  output logic                        run_last_o,
  output logic                        frame_last_o
);
  import ewfe_pkg::*;

  localparam logic [2:0] ST_START  = 3'd0;
  localparam logic [2:0] ST_HDR1   = 3'd1;
  localparam logic [2:0] ST_LO_ESC = 3'd2;
  localparam logic [2:0] ST_LO     = 3'd3;
  localparam logic [2:0] ST_HI_ESC = 3'd4;
  localparam logic [2:0] ST_HI     = 3'd5;
  // Only ever seen as the decoded step, never stored
  localparam logic [2:0] ST_HDR0   = 3'd6;

  logic [2:0]        step_q, step_d, cur;
  logic              load;
  logic [BYTE_W-1:0] byte_sel;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q;
  logic              run_last_q, frame_last_q;

  assign load = head_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    cur = step_q;
    if (step_q == ST_START) begin
      if (head_i.header) begin
        cur = ST_HDR0;
      end else begin
        cur = head_i.esc_lo ? ST_LO_ESC : ST_LO;
      end
    end
  end

  always_comb begin
    byte_sel = ESC_BYTE;
    step_d   = step_q;
    case (cur)
      ST_HDR0: begin
        byte_sel = ESC_BYTE;
        step_d   = ST_HDR1;
      end
      ST_HDR1: begin
        byte_sel = HDR_BYTE;
        step_d   = head_i.esc_lo ? ST_LO_ESC : ST_LO;
      end
      ST_LO_ESC: begin
        byte_sel = ESC_BYTE;
        step_d   = ST_LO;
      end
      ST_LO: begin
        byte_sel = head_i.word[BYTE_W-1:0];
        step_d   = head_i.esc_hi ? ST_HI_ESC : ST_HI;
      end
      ST_HI_ESC: begin
        byte_sel = ESC_BYTE;
        step_d   = ST_HI;
      end
      ST_HI: begin
        byte_sel = head_i.word[WORD_W-1:BYTE_W];
        step_d   = ST_START;
      end
      default: begin
        byte_sel = ESC_BYTE;
        step_d   = ST_START;
      end
    endcase
    if (!load) begin
      step_d = step_q;
    end
  end

  // Retire the word on its high byte
  assign pop_o = load && (cur == ST_HI);

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q   <= byte_sel;
      run_last_q   <= (cur == ST_HI);
      frame_last_q <= (cur == ST_HI) && head_i.frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_START;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign run_last_o   = run_last_q;
  assign frame_last_o = frame_last_q;

endmodule

// ===== design/escaped_word_frame_encoder.sv =====
// Channel  | Handshake                     | Payload
// ---------+-------------------------------+------------------------------------
// in       | in_valid_i / in_stall_o       | word_value_i[15:0]
// out      | out_valid_o / out_stall_i     | out_byte_o[7:0], run_last_o, frame_last_o
//
// One byte leaves per cycle while a word waits and the output is not stalled;
// a word is sent as two bytes, four with a frame header, plus one for each
// escaped byte, from the byte sequencer through its output register.
// A two-entry queue lets words be taken while earlier ones are still sent.
// Reset clears the word position, the queue and the output valid.
// A stalled output holds its byte; input stalls only while the queue is full.
module escaped_word_frame_encoder #(
  parameter int unsigned WORDS_PER_FRAME = ewfe_pkg::WORDS_PER_FRAME_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ewfe_pkg::WORD_W-1:0] word_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ewfe_pkg::BYTE_W-1:0] out_byte_o,
  output logic                        run_last_o,
  output logic                        frame_last_o
);
  import ewfe_pkg::*;

  desc_t push_desc, head_desc;
  logic  q_full, q_push, q_pop, head_valid;

  ewfe_front #(
    .WORDS_PER_FRAME(WORDS_PER_FRAME)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .word_value_i(word_value_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_desc_o    (push_desc)
  );

  ewfe_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .desc_i      (push_desc),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_valid_o(head_valid),
    .head_o      (head_desc)
  );

  ewfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head_desc),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .frame_last_o(frame_last_o)
  );

endmodule

// ===== design/ewfe_checker.sv =====
module ewfe_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [ewfe_pkg::BYTE_W-1:0] out_byte_o,
  input logic                        run_last_o,
  input logic                        frame_last_o
);

  // Hold a stalled byte
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(run_last_o) && $stable(frame_last_o))
    else $error("stalled output byte changed");

  a_frame_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |-> run_last_o)
    else $error("frame end without word end");

  // Input backs up only when the queue is full, which implies a pending byte
  a_stall_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |-> out_valid_o)
    else $error("input stalled with no output pending");

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("not idle after reset");

endmodule

bind escaped_word_frame_encoder ewfe_checker u_ewfe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_byte_o  (out_byte_o),
  .run_last_o  (run_last_o),
  .frame_last_o(frame_last_o)
);

// ===== test/escaped_word_frame_encoder_tb.sv =====
module escaped_word_frame_encoder_tb;
  import ewfe_pkg::*;

  localparam int unsigned FRAME_WORDS = WORDS_PER_FRAME_DEF;
  localparam int unsigned STUCK_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct {
    logic [BYTE_W-1:0] value;
    logic              run_last;
    logic              frame_last;
  } enc_byte_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [WORD_W-1:0] word_value_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [BYTE_W-1:0] out_byte_o;
  logic              run_last_o;
  logic              frame_last_o;

  enc_byte_t   pending_bytes[$];
  int unsigned frame_word_idx;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned out_hold_len;
  int unsigned stuck_cycles;
  int unsigned errors;

  escaped_word_frame_encoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .word_value_i(word_value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .frame_last_o(frame_last_o)
  );

  always #5 clk_i = ~clk_i;

  // Queue one expected byte with its word end and frame end flags
  task automatic push_byte(input logic [BYTE_W-1:0] value, input logic run_end,
                           input logic frame_end);
    enc_byte_t b;
    b.value      = value;
    b.run_last   = run_end;
    b.frame_last = frame_end;
    pending_bytes.push_back(b);
  endtask

  task automatic push_data_byte(input logic [BYTE_W-1:0] value, input logic run_end,
                                input logic frame_end);
    if (value == ESC_BYTE) begin
      push_byte(ESC_BYTE, 1'b0, 1'b0);
    end
    push_byte(value, run_end, run_end & frame_end);
  endtask

  task automatic predict_frame_bytes(input logic [WORD_W-1:0] word);
    int unsigned frame_size;
    logic        last_word;
    frame_size = (FRAME_WORDS == 0) ? 1 : FRAME_WORDS;
    if (frame_word_idx >= frame_size) frame_word_idx = 0;
    last_word = (frame_word_idx + 1 >= frame_size);
    if (frame_word_idx == 0) begin
      push_byte(ESC_BYTE, 1'b0, 1'b0);
      push_byte(HDR_BYTE, 1'b0, 1'b0);
    end
    push_data_byte(word[7:0], 1'b0, last_word);
    push_data_byte(word[15:8], 1'b1, last_word);
    frame_word_idx = last_word ? 0 : frame_word_idx + 1;
  endtask

  // Leaves valid high after acceptance; the caller lowers it or sends again
  task automatic send_word(input logic [WORD_W-1:0] word);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    word_value_i <= word;
    do @(posedge clk_i); while (in_stall_o);
    predict_frame_bytes(word);
  endtask

  task automatic release_input();
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_for_drain();
    while (pending_bytes.size() != 0) @(posedge clk_i);
  endtask

  // Bias bytes toward the escape and header values
  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(7))
      0, 1:    return ESC_BYTE;
      2:       return HDR_BYTE;
      3:       return $urandom_range(1) ? 8'h00 : 8'hFF;
      default: return BYTE_W'($urandom_range(255));
    endcase
  endfunction

  task automatic test_directed_words();
    logic [WORD_W-1:0] words[$];
    send_idle_pct = 0;
    recv_idle_pct = 0;
    words = '{16'h0000, 16'hFFFF, 16'h00FE, 16'hFE00, 16'hFEFE, 16'h0088, 16'h8800,
              16'h88FE, 16'hFE88, 16'h01FD, 16'hFF7F, 16'h8000, 16'h7FFF, 16'h5555,
              16'hAAAA, 16'h00FF, 16'hFEFE, 16'h8888, 16'h1234, 16'hFEFF};
    foreach (words[i]) send_word(words[i]);
    release_input();
  endtask

  task automatic test_random_words(input int unsigned count, input int unsigned s_pct,
                                   input int unsigned r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) send_word({pick_byte(), pick_byte()});
    release_input();
  endtask

  // Hold the output long enough for the queue to fill and the input to stall
  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    out_hold_len  = 150;
    repeat (24) send_word({pick_byte(), pick_byte()});
    release_input();
  endtask

  task automatic test_sender_pause();
    send_idle_pct = 0;
    recv_idle_pct = 30;
    repeat (6) send_word({pick_byte(), pick_byte()});
    release_input();
    wait_for_drain();
    repeat (6) send_word({pick_byte(), pick_byte()});
    release_input();
  endtask

  always @(posedge clk_i) begin
    if (out_hold_len > 0) begin
      out_stall_i  <= 1'b1;
      out_hold_len <= out_hold_len - 1;
    end else begin
      out_stall_i <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    enc_byte_t exp_b;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected byte %0h", out_byte_o);
        errors++;
      end else begin
        exp_b = pending_bytes.pop_front();
        if (out_byte_o !== exp_b.value) begin
          $error("out_byte: expected %0h, got %0h", exp_b.value, out_byte_o);
          errors++;
        end
        if (run_last_o !== exp_b.run_last) begin
          $error("run_last: expected %0b, got %0b", exp_b.run_last, run_last_o);
          errors++;
        end
        if (frame_last_o !== exp_b.frame_last) begin
          $error("frame_last: expected %0b, got %0b", exp_b.frame_last, frame_last_o);
          errors++;
        end
      end
    end
    if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    word_value_i   = '0;
    out_stall_i    = 1'b0;
    frame_word_idx = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    out_hold_len   = 0;
    stuck_cycles   = 0;
    errors         = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_words();
    test_random_words(80, 27, 65);
    test_random_words(80, 65, 27);
    test_output_hold();
    test_sender_pause();
    test_random_words(80, 0, 0);

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
